// ===== rtl/dwd_pkg.sv =====
package dwd_pkg;

	// bias that makes (day_number - 1) nonnegative, a whole number of weeks
	localparam logic [32:0] DAY_BIAS = 33'd2147483652;

	// exact reciprocal for x / 7 with x below 2**19
	localparam int          DIV7_SHIFT = 22;
	localparam logic [19:0] DIV7_MULT  = 20'(((64'd1 << DIV7_SHIFT) + 64'd6) / 64'd7);

	// 400-year cycle split, exact reciprocal for x / 20871 with x below 2**31
	localparam int          CYC_SHIFT = 46;
	localparam logic [15:0] CYC_WEEKS = 16'd20871;
	localparam logic [31:0] CYC_MULT  =
		32'(((64'd1 << CYC_SHIFT) + 64'd20870) / 64'd20871);

	// 4*weeks + 2 rebased so that it is never negative
	localparam logic [31:0] CYC_BIAS  = 32'd18673;
	localparam logic [18:0] CENT_BIAS = 19'd58797;

	// weeks to years mapping
	localparam logic [7:0] YEAR_SLOPE = 8'd157;
	localparam int         YEAR_SHIFT = 13;
	localparam logic [7:0] OFS_BASE   = 8'd18;
	localparam logic [7:0] OFS_STEP   = 8'd22;

	// exact reciprocal for x / 157 with x below 2**13
	localparam int          WK_SHIFT = 21;
	localparam logic [13:0] WK_MULT  = 14'(((64'd1 << WK_SHIFT) + 64'd156) / 64'd157);

	localparam logic signed [23:0] YEARS_PER_CENT = 24'sd100;
	localparam logic signed [23:0] YEAR_TOP       = 24'sd32767;
	localparam logic signed [23:0] YEAR_FLOOR     = -24'sd32769;
	localparam logic [15:0]        YEAR_SAT_HI    = 16'h7fff;
	localparam logic [15:0]        YEAR_SAT_LO    = 16'h8000;

	typedef struct packed {
		logic [31:0] cyc_num;
		logic [2:0]  weekday;
	} wk_t;

	typedef struct packed {
		logic signed [16:0] cent;
		logic [12:0]        sw_q;
		logic [2:0]         weekday;
	} cyc_t;

endpackage

// ===== rtl/day_number_to_iso_week_date.sv =====
// day number to iso week date converter
//
// input channel: day_valid / day_ready carry one word, a signed 32-bit day
// count (day 1 is the first day of year 1, a monday)
// output channel: date_valid / date_ready carry one word per input word:
// iso_year (saturated to signed 16 bits), iso_week 1..53, weekday 1..7
// and in_range, low when the year was saturated
//
// twelve register stages; when nothing stalls, a new word can be accepted
// every cycle. the depth is set by the two divisions by constants (by 7,
// then by the 20871-week cycle), each done as two reciprocal multiplies,
// and the week-to-year multiply that follows
//
// stalls: each stage moves on when it is empty or the next one moves, so
// bubbles close up and the input keeps taking words until every stage is
// full; with the receiver stalled twelve words are held, none lost
// reset clears all valid bits; the block holds no other state
module day_number_to_iso_week_date (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        day_valid,
	output logic        day_ready,
	input  logic [31:0] day_number,
	output logic        date_valid,
	input  logic        date_ready,
	output logic [15:0] iso_year,
	output logic [5:0]  iso_week,
	output logic [2:0]  weekday,
	output logic        in_range
);
	import dwd_pkg::*;

	// weeks elapsed and weekday, rebased to a nonnegative cycle numerator
	wk_t  wk_word;
	logic wk_valid, wk_ready;
	// century and week offset within the 400-year cycle
	cyc_t cyc_word;
	logic cyc_valid, cyc_ready;

	dwd_div7 u_div7 (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (day_valid),
		.in_ready   (day_ready),
		.day_number (day_number),
		.out_valid  (wk_valid),
		.out_ready  (wk_ready),
		.out_word   (wk_word)
	);

	dwd_cyc u_cyc (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (wk_valid),
		.in_ready  (wk_ready),
		.in_word   (wk_word),
		.out_valid (cyc_valid),
		.out_ready (cyc_ready),
		.out_word  (cyc_word)
	);

	// linear map to years and week, then year saturation
	dwd_year u_year (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cyc_valid),
		.in_ready  (cyc_ready),
		.in_word   (cyc_word),
		.out_valid (date_valid),
		.out_ready (date_ready),
		.iso_year  (iso_year),
		.iso_week  (iso_week),
		.weekday   (weekday),
		.in_range  (in_range)
	);

	// an empty or draining output stage always opens the input
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		(!date_valid || date_ready) |-> day_ready)
		else $error("input blocked while output stage can move");

	// weekday is 3 bits wide, so 1..7 means anything but zero
	a_weekday: assert property (@(posedge clk) disable iff (!arst_n)
		date_valid |-> (weekday != 3'd0))
		else $error("weekday out of range");

	a_week: assert property (@(posedge clk) disable iff (!arst_n)
		date_valid |-> (iso_week >= 6'd1 && iso_week <= 6'd53))
		else $error("week out of range");

	a_saturate: assert property (@(posedge clk) disable iff (!arst_n)
		(date_valid && !in_range) |-> (iso_year == YEAR_SAT_HI || iso_year == YEAR_SAT_LO))
		else $error("out of range word without saturated year");

endmodule

// ===== rtl/dwd_div7.sv =====
module dwd_div7 (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [31:0]     day_number,
	output logic            out_valid,
	input  logic            out_ready,
	output dwd_pkg::wk_t    out_word
);
	import dwd_pkg::*;

	logic        valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic        en_s1, en_s2, en_s3, en_s4, en_s5;
	logic [32:0] u_s1;
	logic [36:0] ph_s2;
	logic [16:0] hi_s2;
	logic [15:0] lo_s2;
	logic [14:0] qh_s3, qh_s4;
	logic [18:0] x2_s3;
	logic [38:0] p2_s4;
	logic [2:0]  x2lo_s4;
	logic [14:0] qh;
	logic [2:0]  rh;
	logic [15:0] q2;
	logic [2:0]  r2;
	wk_t         word_s5;

	assign en_s5    = !valid_s5 || out_ready;
	assign en_s4    = !valid_s4 || en_s5;
	assign en_s3    = !valid_s3 || en_s4;
	assign en_s2    = !valid_s2 || en_s3;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_ready = en_s1;

	// remainders only need their low bits: x - 7q == x + q mod 8
	assign qh = ph_s2[DIV7_SHIFT+14:DIV7_SHIFT];
	assign rh = hi_s2[2:0] + qh[2:0];
	assign q2 = p2_s4[DIV7_SHIFT+15:DIV7_SHIFT];
	assign r2 = x2lo_s4 + q2[2:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= in_valid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3;
			if (en_s5) valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			u_s1 <= {day_number[31], day_number} + DAY_BIAS;
		end
		if (en_s2) begin
			ph_s2 <= u_s1[32:16] * DIV7_MULT;
			hi_s2 <= u_s1[32:16];
			lo_s2 <= u_s1[15:0];
		end
		if (en_s3) begin
			qh_s3 <= qh;
			x2_s3 <= {rh, lo_s2};
		end
		if (en_s4) begin
			p2_s4   <= x2_s3 * DIV7_MULT;
			x2lo_s4 <= x2_s3[2:0];
			qh_s4   <= qh_s3;
		end
		if (en_s5) begin
			word_s5.cyc_num <= 32'({qh_s4, q2, 2'b00}) + CYC_BIAS;
			word_s5.weekday <= r2 + 3'd1;
		end
	end

	assign out_valid = valid_s5;
	assign out_word  = word_s5;

endmodule

// ===== rtl/dwd_cyc.sv =====
module dwd_cyc (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  dwd_pkg::wk_t    in_word,
	output logic            out_valid,
	input  logic            out_ready,
	output dwd_pkg::cyc_t   out_word
);
	import dwd_pkg::*;

	logic        valid_s6, valid_s7, valid_s8, valid_s9;
	logic        en_s6, en_s7, en_s8, en_s9;
	logic [47:0] ph2_s6;
	logic [15:0] hi2_s6, lo2_s6;
	logic [2:0]  wd_s6, wd_s7, wd_s8;
	logic [1:0]  qh2_s7, qh2_s8;
	logic [30:0] x3_s7, x3_s8;
	logic [62:0] p3_s8;
	logic [1:0]  qh2;
	logic [15:0] rh2;
	logic [15:0] q3;
	logic [30:0] sw;
	cyc_t        word_s9;

	assign en_s9    = !valid_s9 || out_ready;
	assign en_s8    = !valid_s8 || en_s9;
	assign en_s7    = !valid_s7 || en_s8;
	assign en_s6    = !valid_s6 || en_s7;
	assign in_ready = en_s6;

	assign qh2 = ph2_s6[CYC_SHIFT+1:CYC_SHIFT];
	assign rh2 = hi2_s6 - 16'(qh2) * CYC_WEEKS;
	assign q3  = p3_s8[CYC_SHIFT+15:CYC_SHIFT];
	assign sw  = x3_s8 - 31'(q3) * 31'(CYC_WEEKS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
			valid_s9 <= 1'b0;
		end else begin
			if (en_s6) valid_s6 <= in_valid;
			if (en_s7) valid_s7 <= valid_s6;
			if (en_s8) valid_s8 <= valid_s7;
			if (en_s9) valid_s9 <= valid_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s6) begin
			ph2_s6 <= in_word.cyc_num[31:16] * CYC_MULT;
			hi2_s6 <= in_word.cyc_num[31:16];
			lo2_s6 <= in_word.cyc_num[15:0];
			wd_s6  <= in_word.weekday;
		end
		if (en_s7) begin
			qh2_s7 <= qh2;
			x3_s7  <= {rh2[14:0], lo2_s6};
			wd_s7  <= wd_s6;
		end
		if (en_s8) begin
			p3_s8  <= x3_s7 * CYC_MULT;
			x3_s8  <= x3_s7;
			qh2_s8 <= qh2_s7;
			wd_s8  <= wd_s7;
		end
		if (en_s9) begin
			// rebased quotient back to a signed century count
			word_s9.cent    <= 17'({1'b0, qh2_s8, q3} - CENT_BIAS);
			word_s9.sw_q    <= sw[14:2];
			word_s9.weekday <= wd_s8;
		end
	end

	assign out_valid = valid_s9;
	assign out_word  = word_s9;

endmodule

// ===== rtl/dwd_year.sv =====
module dwd_year (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  dwd_pkg::cyc_t   in_word,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [15:0]     iso_year,
	output logic [5:0]      iso_week,
	output logic [2:0]      weekday,
	output logic            in_range
);
	import dwd_pkg::*;

	logic                valid_s10, valid_s11, valid_s12;
	logic                en_s10, en_s11, en_s12;
	logic [19:0]         scaled_s10;
	logic signed [16:0]  cent_s10;
	logic [2:0]          wd_s10, wd_s11;
	logic [26:0]         pf_s11;
	logic signed [23:0]  years_s11;
	logic [15:0]         year_s12;
	logic [5:0]          week_s12;
	logic [2:0]          wd_s12;
	logic                inr_s12;
	logic [6:0]          cy;

	function automatic logic [7:0] cent_offset(input logic [1:0] cl);
		logic [2:0] c;
		unique case (cl)
			2'd0: c = 3'd3;
			2'd1: c = 3'd5;
			2'd2: c = 3'd0;
			2'd3: c = 3'd2;
			default: c = 3'd0;
		endcase
		return OFS_BASE + 8'(c) * OFS_STEP;
	endfunction

	assign en_s12   = !valid_s12 || out_ready;
	assign en_s11   = !valid_s11 || en_s12;
	assign en_s10   = !valid_s10 || en_s11;
	assign in_ready = en_s10;

	assign cy = scaled_s10[YEAR_SHIFT+6:YEAR_SHIFT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s10 <= 1'b0;
			valid_s11 <= 1'b0;
			valid_s12 <= 1'b0;
		end else begin
			if (en_s10) valid_s10 <= in_valid;
			if (en_s11) valid_s11 <= valid_s10;
			if (en_s12) valid_s12 <= valid_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s10) begin
			scaled_s10 <= 20'(in_word.sw_q) * 20'(YEAR_SLOPE)
				+ 20'(cent_offset(in_word.cent[1:0]));
			cent_s10   <= in_word.cent;
			wd_s10     <= in_word.weekday;
		end
		if (en_s11) begin
			pf_s11    <= scaled_s10[YEAR_SHIFT-1:0] * WK_MULT;
			years_s11 <= 24'(cent_s10) * YEARS_PER_CENT + signed'({17'd0, cy});
			wd_s11    <= wd_s10;
		end
		if (en_s12) begin
			priority if (years_s11 >= YEAR_TOP) begin
				year_s12 <= YEAR_SAT_HI;
				inr_s12  <= 1'b0;
			end else if (years_s11 < YEAR_FLOOR) begin
				year_s12 <= YEAR_SAT_LO;
				inr_s12  <= 1'b0;
			end else begin
				year_s12 <= 16'(years_s11 + 24'sd1);
				inr_s12  <= 1'b1;
			end
			week_s12 <= pf_s11[WK_SHIFT+5:WK_SHIFT] + 6'd1;
			wd_s12   <= wd_s11;
		end
	end

	assign out_valid = valid_s12;
	assign iso_year  = year_s12;
	assign iso_week  = week_s12;
	assign weekday   = wd_s12;
	assign in_range  = inr_s12;

endmodule
